[hdl/ccd_pkg.sv]
// Shared constants for the capped cylinder distance pipeline.
// Holds coordinate widths, register index codes and the square root step count.
// No dependencies.
package ccd_pkg;

    localparam int COORD_W = 24;
    localparam int LEN_W   = 23;
    localparam int CFG_IDX_W = 3;

    // Root bits resolved per square root pipeline stage
    localparam int SQRT_STEPS = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CYL_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CYL_HEIGHT = 3'd4;

    localparam logic [LEN_W-1:0] RADIUS_RESET = 23'd205;
    localparam logic [LEN_W-1:0] HEIGHT_RESET = 23'd819;

endpackage

[hdl/ccd_isqrt_pipe.sv]
// Pipelined floor integer square root with a sideband word carried alongside.
// Resolves ccd_pkg::SQRT_STEPS root bits per stage; depends on ccd_pkg.
// All stages advance together on en.
module ccd_isqrt_pipe #(
    parameter int RAD_W  = 52,
    parameter int SIDE_W = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [RAD_W-1:0]               radicand,
    input  logic [SIDE_W-1:0]              side_in,
    output logic                           out_valid,
    output logic [(RAD_W+1)/2-1:0]         root,
    output logic [SIDE_W-1:0]              side_out
);

    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int PAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int STEPS  = ccd_pkg::SQRT_STEPS;
    localparam int NSTAGE = (ROOT_W + STEPS - 1) / STEPS;

    logic [PAD_W-1:0]  rad_reg   [NSTAGE];
    logic [REM_W-1:0]  rem_reg   [NSTAGE];
    logic [ROOT_W-1:0] root_reg  [NSTAGE];
    logic [SIDE_W-1:0] side_reg  [NSTAGE];
    logic [NSTAGE-1:0] valid_reg;

    logic [PAD_W-1:0]  rad_pad;

    assign rad_pad = PAD_W'(radicand);

    for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
        logic [PAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SIDE_W-1:0] side_stage_in;
        logic              valid_in;
        logic [PAD_W-1:0]  rad_next;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (s == 0) begin : g_first
            assign rad_in        = rad_pad;
            assign rem_in        = '0;
            assign root_in       = '0;
            assign side_stage_in = side_in;
            assign valid_in      = in_valid;
        end else begin : g_rest
            assign rad_in        = rad_reg[s-1];
            assign rem_in        = rem_reg[s-1];
            assign root_in       = root_reg[s-1];
            assign side_stage_in = side_reg[s-1];
            assign valid_in      = valid_reg[s-1];
        end

        always_comb
        begin : step_logic
            logic [PAD_W-1:0]  rad_v;
            logic [REM_W-1:0]  rem_v;
            logic [REM_W-1:0]  trial_v;
            logic [ROOT_W-1:0] root_v;
            rad_v  = rad_in;
            rem_v  = rem_in;
            root_v = root_in;
            for (int j = 0; j < STEPS; j++) begin
                if (s * STEPS + j < ROOT_W) begin
                    // bring down the next two radicand bits
                    rem_v   = {rem_v[REM_W-3:0], rad_v[PAD_W-1 -: 2]};
                    rad_v   = {rad_v[PAD_W-3:0], 2'b00};
                    trial_v = {root_v, 2'b01};
                    if (rem_v >= trial_v) begin
                        rem_v  = rem_v - trial_v;
                        root_v = {root_v[ROOT_W-2:0], 1'b1};
                    end else begin
                        root_v = {root_v[ROOT_W-2:0], 1'b0};
                    end
                end
            end
            rad_next  = rad_v;
            rem_next  = rem_v;
            root_next = root_v;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s]  <= rad_next;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                side_reg[s] <= side_stage_in;
            end
        end
    end

    assign out_valid = valid_reg[NSTAGE-1];
    assign root      = root_reg[NSTAGE-1];
    assign side_out  = side_reg[NSTAGE-1];

endmodule

[hdl/capped_cylinder_distance.sv]
// Capped cylinder signed distance: one Q12.12 point in, one Q12.12 distance out.
// Input channel: in_valid / in_stall with point_x, point_y, point_z.
// Output channel: out_valid / out_stall with signed_distance, negative inside.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 centre_x,
// 1 centre_y, 2 centre_z, 3 cyl_radius, 4 cyl_height); other indexes are ignored.
// Write configuration only while the pipeline is empty.
// The pipeline has four front stages, two 7-stage square root units
// (26 and 27 root bits, four per stage), three middle stages and two back stages.
// Unless stalled, throughput is one word per cycle and every stage takes a new word.
// When out_stall is high with a word waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset empties the pipeline and loads centre 0, radius 205, height 819.
// Radius and height below MIN_RADIUS_Q / MIN_HEIGHT_Q are raised when used.
// Depends on ccd_pkg and ccd_isqrt_pipe.
module capped_cylinder_distance #(
    parameter logic [22:0] MIN_RADIUS_Q = 23'd41,
    parameter logic [22:0] MIN_HEIGHT_Q = 23'd41
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] point_x,
    input  logic signed [23:0] point_y,
    input  logic signed [23:0] point_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] signed_distance
);

    localparam logic signed [27:0] OUT_MAX = 28'sd8388607;
    localparam logic signed [27:0] OUT_MIN = -28'sd8388608;

    // configuration registers
    logic signed [23:0] cx_reg, cy_reg, cz_reg;
    logic [22:0]        radius_reg, height_reg;
    logic [22:0]        r_eff, h_eff;

    logic en;

    // stage 1: doubled offsets
    logic signed [25:0] dx_reg, dy_reg, dz_reg;
    logic signed [24:0] diff_x, diff_y, diff_z;
    logic               v1_reg;
    // stage 2: magnitudes and vertical excess
    logic [25:0]        ax_reg, ay_reg;
    logic [25:0]        ax_next, ay_next, az_next;
    logic signed [26:0] vert2_reg;
    logic               v2_reg;
    // stage 3: squares
    logic [51:0]        sqx_reg, sqy_reg;
    logic signed [26:0] vert3_reg;
    logic               v3_reg;
    // stage 4: radial radicand
    logic [51:0]        rsum_reg;
    logic signed [26:0] vert4_reg;
    logic               v4_reg;
    // first square root
    logic               sq1_valid;
    logic [25:0]        rho;
    logic [26:0]        sq1_side;
    // stage 5: positive parts and inside term
    logic signed [27:0] radial, vert5, mx;
    logic [25:0]        orad_reg, over_reg;
    logic signed [27:0] inside5_reg;
    logic               v5_reg;
    // stage 6
    logic [51:0]        sqr_reg, sqv_reg;
    logic signed [27:0] inside6_reg;
    logic               v6_reg;
    // stage 7
    logic [52:0]        osum_reg;
    logic signed [27:0] inside7_reg;
    logic               v7_reg;
    // second square root
    logic               sq2_valid;
    logic [26:0]        outside;
    logic [27:0]        sq2_side;
    // stage 8: Q.13 total
    logic signed [28:0] total_reg;
    logic               v8_reg;
    // stage 9: rounded, saturated output
    logic signed [28:0] rounded;
    logic signed [27:0] half;
    logic signed [23:0] dist_reg;
    logic signed [23:0] dist_next;
    logic               out_valid_reg;

    // hold every stage while a finished word waits on a stalled receiver
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    assign r_eff = (radius_reg < MIN_RADIUS_Q) ? MIN_RADIUS_Q : radius_reg;
    assign h_eff = (height_reg < MIN_HEIGHT_Q) ? MIN_HEIGHT_Q : height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            radius_reg <= ccd_pkg::RADIUS_RESET;
            height_reg <= ccd_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ccd_pkg::CFG_CENTRE_X:   cx_reg     <= cfg_data;
                ccd_pkg::CFG_CENTRE_Y:   cy_reg     <= cfg_data;
                ccd_pkg::CFG_CENTRE_Z:   cz_reg     <= cfg_data;
                ccd_pkg::CFG_CYL_RADIUS: radius_reg <= cfg_data[22:0];
                ccd_pkg::CFG_CYL_HEIGHT: height_reg <= cfg_data[22:0];
                default: ;
            endcase
        end
    end

    assign diff_x = {point_x[23], point_x} - {cx_reg[23], cx_reg};
    assign diff_y = {point_y[23], point_y} - {cy_reg[23], cy_reg};
    assign diff_z = {point_z[23], point_z} - {cz_reg[23], cz_reg};

    assign ax_next = dx_reg[25] ? 26'(-dx_reg) : 26'(dx_reg);
    assign ay_next = dy_reg[25] ? 26'(-dy_reg) : 26'(dy_reg);
    assign az_next = dz_reg[25] ? 26'(-dz_reg) : 26'(dz_reg);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= sq1_valid;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            v8_reg        <= sq2_valid;
            out_valid_reg <= v8_reg;
        end
    end

    // front stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= {diff_x, 1'b0};
            dy_reg    <= {diff_y, 1'b0};
            dz_reg    <= {diff_z, 1'b0};
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            vert2_reg <= $signed({1'b0, az_next}) - $signed({4'b0, h_eff});
            sqx_reg   <= ax_reg * ax_reg;
            sqy_reg   <= ay_reg * ay_reg;
            vert3_reg <= vert2_reg;
            rsum_reg  <= sqx_reg + sqy_reg;
            vert4_reg <= vert3_reg;
        end
    end

    ccd_isqrt_pipe #(
        .RAD_W  (52),
        .SIDE_W (27)
    ) u_sqrt_radial (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .radicand  (rsum_reg),
        .side_in   (vert4_reg),
        .out_valid (sq1_valid),
        .root      (rho),
        .side_out  (sq1_side)
    );

    assign radial = $signed({2'b0, rho}) - $signed({4'b0, r_eff, 1'b0});
    assign vert5  = {sq1_side[26], sq1_side};
    assign mx     = (radial > vert5) ? radial : vert5;

    // middle stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            orad_reg    <= (radial > 0) ? radial[25:0] : '0;
            over_reg    <= (vert5 > 0) ? vert5[25:0] : '0;
            inside5_reg <= mx[27] ? mx : '0;
            sqr_reg     <= orad_reg * orad_reg;
            sqv_reg     <= over_reg * over_reg;
            inside6_reg <= inside5_reg;
            osum_reg    <= {1'b0, sqr_reg} + {1'b0, sqv_reg};
            inside7_reg <= inside6_reg;
        end
    end

    ccd_isqrt_pipe #(
        .RAD_W  (53),
        .SIDE_W (28)
    ) u_sqrt_outside (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .radicand  (osum_reg),
        .side_in   (inside7_reg),
        .out_valid (sq2_valid),
        .root      (outside),
        .side_out  (sq2_side)
    );

    // round half up from Q.13 to Q12.12, then clamp
    assign rounded = total_reg + 29'sd1;
    assign half    = 28'(rounded >>> 1);

    always_comb
    begin
        if (half > OUT_MAX)
            dist_next = OUT_MAX[23:0];
        else if (half < OUT_MIN)
            dist_next = OUT_MIN[23:0];
        else
            dist_next = half[23:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            total_reg <= $signed({2'b0, outside}) + $signed({sq2_side[27], sq2_side});
            dist_reg  <= dist_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign signed_distance = dist_reg;

endmodule
